// ===== hw/rtl/psc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package psc_pkg;

    // payload widths
    localparam int RANGE_W = 16;
    localparam int ANGLE_W = 16;
    localparam int COORD_W = 17;
    localparam int BEAM_W  = 10;
    localparam int CFG_W   = 16;
    localparam int ADDR_W  = 1;

    // datapath: q.14 vectors and q0.32 turn angle, with headroom
    localparam int DATA_W    = 34;
    localparam int FRAC_BITS = 14;
    localparam int COORD_MAX = 65535;

    // inverse rotation gain, round(0.6072529350 * 2^30)
    localparam int                GAIN_W     = 30;
    localparam logic [GAIN_W-1:0] GAIN_Q30   = 30'd652032874;
    localparam int                GAIN_SHIFT = 16;

    // quadrant folding limits in 2^-16 turn
    localparam int QUARTER_TURN = 16384;
    localparam int HALF_TURN    = 32768;

    localparam int ATAN_ENTRIES = 24;
    localparam int ATAN_W       = 32;
    localparam int ITER_W       = 5;

    localparam int MAX_BEAMS_DEF = 1024;
    localparam int ROT_STEPS_DEF = 16;

    // register indexes
    localparam logic [ADDR_W-1:0] REG_ANGLE_STEP   = 1'd0;
    localparam logic [ADDR_W-1:0] REG_START_OFFSET = 1'd1;

    typedef struct packed {
        logic              load;
        logic [DATA_W-1:0] x0;
        logic [DATA_W-1:0] z0;
    } cordic_ctrl_t;

    typedef struct packed {
        logic              busy;
        logic              last;
        logic [DATA_W-1:0] x;
        logic [DATA_W-1:0] y;
    } cordic_stat_t;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [ATAN_W-1:0] atan_turn(input logic [ITER_W-1:0] i);
        logic [ATAN_W-1:0] a;
        unique case (i)
            5'd0:    a = 32'h20000000;
            5'd1:    a = 32'h12E4051D;
            5'd2:    a = 32'h09FB385B;
            5'd3:    a = 32'h051111D4;
            5'd4:    a = 32'h028B0D43;
            5'd5:    a = 32'h0145D7E1;
            5'd6:    a = 32'h00A2F61E;
            5'd7:    a = 32'h00517C55;
            5'd8:    a = 32'h0028BE53;
            5'd9:    a = 32'h00145F2E;
            5'd10:   a = 32'h000A2F98;
            5'd11:   a = 32'h000517CC;
            5'd12:   a = 32'h00028BE6;
            5'd13:   a = 32'h000145F3;
            5'd14:   a = 32'h0000A2F9;
            5'd15:   a = 32'h0000517C;
            5'd16:   a = 32'h000028BE;
            5'd17:   a = 32'h0000145F;
            5'd18:   a = 32'h00000A2F;
            5'd19:   a = 32'h00000517;
            5'd20:   a = 32'h0000028B;
            5'd21:   a = 32'h00000145;
            5'd22:   a = 32'h000000A2;
            5'd23:   a = 32'h00000051;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/polar_scan_to_cartesian.sv =====
`timescale 1ns / 1ps
`default_nettype none

// an input beat is registered, the setup state loads the rotation unit, the rotation runs,
// and the done state loads the output register once it is free; a new beam is taken only
// in idle, as the single shift-add rotation unit works one iteration per cycle
// a finished result waits in the output register while the next beam is taken in
// reset (aresetn low, synchronous) clears the beam counter, both registers and all valids

module polar_scan_to_cartesian #(
    parameter int MAX_BEAMS      = psc_pkg::MAX_BEAMS_DEF,
    parameter int ROTATION_STEPS = psc_pkg::ROT_STEPS_DEF
) (
    input  wire                                aclk,
    input  wire                                aresetn,

    input  wire                                cfg_wr_en,
    input  wire  [psc_pkg::ADDR_W-1:0]         cfg_addr,
    input  wire  [psc_pkg::CFG_W-1:0]          cfg_wr_data,

    input  wire                                s_valid,
    output logic                               s_ready,
    input  wire  [psc_pkg::RANGE_W-1:0]        s_range_sample,
    input  wire                                s_first_beam,

    output logic                               m_valid,
    input  wire                                m_ready,
    output logic signed [psc_pkg::COORD_W-1:0] m_x_coord,
    output logic signed [psc_pkg::COORD_W-1:0] m_y_coord,
    output logic [psc_pkg::BEAM_W-1:0]         m_beam_number
);

    localparam int CNT_W = (MAX_BEAMS > 1) ? $clog2(MAX_BEAMS) : 1;
    localparam int AW    = psc_pkg::ANGLE_W;
    localparam int PW    = psc_pkg::RANGE_W + psc_pkg::GAIN_W;
    localparam int DW    = psc_pkg::DATA_W;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SETUP  = 4'b0010,
        S_ROTATE = 4'b0100,
        S_DONE   = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [AW-1:0]    angle_step_reg;
    logic [AW-1:0]    start_offset_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic [psc_pkg::RANGE_W-1:0] range_reg;
    logic [psc_pkg::BEAM_W-1:0]  beam_reg;
    logic [AW-1:0]               prod_reg;
    logic                        flip_reg, flip_next;

    logic                               m_valid_reg, m_valid_next;
    logic signed [psc_pkg::COORD_W-1:0] x_out_reg, x_out_next;
    logic signed [psc_pkg::COORD_W-1:0] y_out_reg, y_out_next;
    logic [psc_pkg::BEAM_W-1:0]         beam_out_reg, beam_out_next;

    psc_pkg::cordic_ctrl_t ctrl;
    psc_pkg::cordic_stat_t stat;

    logic                        accept;
    logic                        out_load;
    logic [CNT_W-1:0]            idx_sel;
    logic [CNT_W:0]              idx_plus;
    logic [CNT_W+AW-1:0]         idx_wide;
    logic [CNT_W+psc_pkg::BEAM_W-1:0] beam_wide;
    logic [2*AW-1:0]             mult_full;
    logic [AW-1:0]               ang_u;
    logic signed [AW:0]          ang_s;
    logic signed [AW:0]          ang_red;
    logic [PW-1:0]               gain_prod;

    function automatic logic [psc_pkg::COORD_W-1:0] round_sat(
        input logic signed [DW-1:0] v,
        input logic                 flip
    );
        logic                        neg;
        logic [DW-1:0]               mag;
        logic [DW-1:0]               rnd;
        logic [psc_pkg::COORD_W-1:0] r;
        neg = v[DW-1] ^ flip;
        mag = v[DW-1] ? DW'(-v) : DW'(v);
        rnd = (mag + DW'(1 << (psc_pkg::FRAC_BITS - 1))) >> psc_pkg::FRAC_BITS;
        r   = (rnd > DW'(psc_pkg::COORD_MAX)) ? psc_pkg::COORD_W'(psc_pkg::COORD_MAX)
                                              : rnd[psc_pkg::COORD_W-1:0];
        return neg ? -r : r;
    endfunction

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_load = (state_reg == S_DONE) && (!m_valid_reg || m_ready);

    // beam index and wrap
    assign idx_sel   = s_first_beam ? '0 : cnt_reg;
    assign idx_plus  = {1'b0, idx_sel} + 1'b1;
    assign cnt_next  = (idx_plus == (CNT_W+1)'(MAX_BEAMS)) ? '0 : idx_plus[CNT_W-1:0];
    assign idx_wide  = (CNT_W+AW)'(idx_sel);
    assign beam_wide = (CNT_W+psc_pkg::BEAM_W)'(idx_sel);
    assign mult_full = (2*AW)'(idx_wide[AW-1:0]) * (2*AW)'(angle_step_reg);

    // angle and quadrant fold into [-1/4, +1/4] turn
    assign ang_u = prod_reg - start_offset_reg;
    assign ang_s = (AW+1)'($signed(ang_u));

    always_comb begin
        ang_red   = ang_s;
        flip_next = 1'b0;
        if (ang_s > (AW+1)'(psc_pkg::QUARTER_TURN)) begin
            ang_red   = ang_s - (AW+1)'(psc_pkg::HALF_TURN);
            flip_next = 1'b1;
        end else if (ang_s < -(AW+1)'(psc_pkg::QUARTER_TURN)) begin
            ang_red   = ang_s + (AW+1)'(psc_pkg::HALF_TURN);
            flip_next = 1'b1;
        end
    end

    assign gain_prod = PW'(range_reg) * PW'(psc_pkg::GAIN_Q30);

    assign ctrl.load = (state_reg == S_SETUP);
    assign ctrl.x0   = DW'(gain_prod[PW-1:psc_pkg::GAIN_SHIFT]);
    assign ctrl.z0   = {{(DW-AW-1-AW){ang_red[AW]}}, ang_red, {AW{1'b0}}};

    psc_cordic #(
        .ROTATION_STEPS(ROTATION_STEPS)
    ) u_cordic (
        .aclk   (aclk),
        .aresetn(aresetn),
        .ctrl   (ctrl),
        .stat   (stat)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_SETUP;
                end
            end
            S_SETUP: begin
                state_next = S_ROTATE;
            end
            S_ROTATE: begin
                if (stat.last) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next  = m_valid_reg && !m_ready;
        x_out_next    = x_out_reg;
        y_out_next    = y_out_reg;
        beam_out_next = beam_out_reg;
        if (out_load) begin
            m_valid_next  = 1'b1;
            x_out_next    = $signed(round_sat($signed(stat.x), flip_reg));
            y_out_next    = $signed(round_sat($signed(stat.y), flip_reg));
            beam_out_next = beam_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            cnt_reg          <= '0;
            angle_step_reg   <= '0;
            start_offset_reg <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (accept) begin
                cnt_reg <= cnt_next;
            end
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    psc_pkg::REG_ANGLE_STEP:   angle_step_reg   <= cfg_wr_data;
                    psc_pkg::REG_START_OFFSET: start_offset_reg <= cfg_wr_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            range_reg <= s_range_sample;
            beam_reg  <= beam_wide[psc_pkg::BEAM_W-1:0];
            prod_reg  <= mult_full[AW-1:0];
        end
        if (state_reg == S_SETUP) begin
            flip_reg <= flip_next;
        end
        x_out_reg    <= x_out_next;
        y_out_reg    <= y_out_next;
        beam_out_reg <= beam_out_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_x_coord     = x_out_reg;
    assign m_y_coord     = y_out_reg;
    assign m_beam_number = beam_out_reg;

    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.busy |-> !s_ready)
        else $error("input ready while rotation running");

    a_valid_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == S_DONE))
        else $error("result beat raised outside done state");

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, cnt_reg} < (CNT_W+1)'(MAX_BEAMS))
        else $error("beam counter past beam bound");

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == S_SETUP) ##1 stat.busy)
        else $error("accepted beat did not start rotation");

endmodule

`default_nettype wire

// ===== hw/rtl/psc_cordic.sv =====
`timescale 1ns / 1ps
`default_nettype none

module psc_cordic #(
    parameter int ROTATION_STEPS = psc_pkg::ROT_STEPS_DEF
) (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  psc_pkg::cordic_ctrl_t  ctrl,
    output psc_pkg::cordic_stat_t  stat
);

    localparam int STEPS = (ROTATION_STEPS > psc_pkg::ATAN_ENTRIES) ?
                           psc_pkg::ATAN_ENTRIES : ROTATION_STEPS;
    localparam logic [psc_pkg::ITER_W-1:0] LAST_ITER = psc_pkg::ITER_W'(STEPS - 1);

    logic                              run_reg,  run_next;
    logic [psc_pkg::ITER_W-1:0]        iter_reg, iter_next;
    logic signed [psc_pkg::DATA_W-1:0] x_reg, x_next;
    logic signed [psc_pkg::DATA_W-1:0] y_reg, y_next;
    logic signed [psc_pkg::DATA_W-1:0] z_reg, z_next;

    logic signed [psc_pkg::DATA_W-1:0] dx;
    logic signed [psc_pkg::DATA_W-1:0] dy;
    logic signed [psc_pkg::DATA_W-1:0] atan_val;

    // floor shift of the cross terms
    assign dx       = y_reg >>> iter_reg;
    assign dy       = x_reg >>> iter_reg;
    assign atan_val = $signed(psc_pkg::DATA_W'(psc_pkg::atan_turn(iter_reg)));

    always_comb begin
        run_next  = run_reg;
        iter_next = iter_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        if (ctrl.load) begin
            x_next    = $signed(ctrl.x0);
            y_next    = '0;
            z_next    = $signed(ctrl.z0);
            iter_next = '0;
            run_next  = 1'b1;
        end else if (run_reg) begin
            if (!z_reg[psc_pkg::DATA_W-1]) begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - atan_val;
            end else begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + atan_val;
            end
            iter_next = iter_reg + 1'b1;
            if (iter_reg == LAST_ITER) begin
                run_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            iter_reg <= '0;
        end else begin
            run_reg  <= run_next;
            iter_reg <= iter_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign stat.busy = run_reg;
    assign stat.last = run_reg && (iter_reg == LAST_ITER);
    assign stat.x    = x_reg;
    assign stat.y    = y_reg;

    a_no_load_while_running: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.load |-> !run_reg)
        else $error("rotation restarted while running");

    a_iter_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        run_reg |-> (iter_reg <= LAST_ITER))
        else $error("iteration count past table end");

    a_stop_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(run_reg) |-> ($past(iter_reg) == LAST_ITER))
        else $error("rotation stopped early");

endmodule

`default_nettype wire

// ===== tb/tb_polar_scan_to_cartesian.sv =====
`timescale 1ns / 1ps

module tb_polar_scan_to_cartesian;

    localparam int MAX_BEAMS      = 1024;
    localparam int ROTATION_STEPS = 16;
    localparam int LATENCY        = ROTATION_STEPS + 3;
    localparam int DRAIN_CYCLES   = 2 * LATENCY;
    localparam int HOLD_CYCLES    = 300;
    localparam int STALL_LIMIT    = 4000;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_TOGGLE
    } rx_mode_t;

    class beam_point_checker #(int BEAMS = 1024, int STEPS = 16);
        typedef logic signed [psc_pkg::COORD_W-1:0] coord_t;
        typedef logic [psc_pkg::BEAM_W-1:0]         beam_t;
        typedef struct packed {
            coord_t x;
            coord_t y;
            beam_t  beam;
        } beam_point_t;

        localparam longint unsigned GAIN_Q30  = 652032874;
        localparam int              FRAC      = 14;
        localparam longint          SAT_LIMIT = 65535;
        localparam int              TABLE_LEN = 24;

        logic [psc_pkg::ANGLE_W-1:0] angle_step;
        logic [psc_pkg::ANGLE_W-1:0] start_offset;
        int unsigned                 next_beam;
        int                          errors;
        longint                      atan_q32[TABLE_LEN];
        beam_point_t                 expected_points[$];

        function new();
            // atan(2^-i) in 2^-32 turn
            atan_q32 = '{
                64'h20000000, 64'h12E4051D, 64'h09FB385B, 64'h051111D4,
                64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
                64'h0028BE53, 64'h00145F2E, 64'h000A2F98, 64'h000517CC,
                64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517C,
                64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
                64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051
            };
            angle_step   = '0;
            start_offset = '0;
            next_beam    = 0;
            errors       = 0;
        endfunction

        function void set_reg(logic [psc_pkg::ADDR_W-1:0] idx,
                              logic [psc_pkg::CFG_W-1:0] value);
            if (idx == psc_pkg::REG_ANGLE_STEP) begin
                angle_step = value;
            end else if (idx == psc_pkg::REG_START_OFFSET) begin
                start_offset = value;
            end
        endfunction

        // remove the fraction bits, halves away from zero, then clamp
        function longint round_coord(longint v);
            longint unsigned mag;
            longint          r;
            mag = (v < 0) ? longint'(-v) : longint'(v);
            mag = (mag + (64'd1 << (FRAC - 1))) >> FRAC;
            if (mag > SAT_LIMIT) begin
                mag = SAT_LIMIT;
            end
            r = longint'(mag);
            return (v < 0) ? -r : r;
        endfunction

        function beam_point_t project_beam(logic [psc_pkg::RANGE_W-1:0] range,
                                           int unsigned idx);
            logic [psc_pkg::ANGLE_W-1:0] ang_u;
            int                          ang;
            bit                          negate;
            longint                      x;
            longint                      y;
            longint                      z;
            longint                      dx;
            longint                      dy;
            int                          steps;
            beam_point_t                 p;
            ang_u  = 16'(idx * angle_step - start_offset);
            ang    = int'($signed(ang_u));
            negate = 1'b0;
            // fold into the right half plane
            if (ang > 16384) begin
                ang    = ang - 32768;
                negate = 1'b1;
            end else if (ang < -16384) begin
                ang    = ang + 32768;
                negate = 1'b1;
            end
            x = longint'((longint'(range) * GAIN_Q30) >> 16);
            y = 0;
            z = longint'(ang) * 65536;
            steps = (STEPS > TABLE_LEN) ? TABLE_LEN : STEPS;
            for (int i = 0; i < steps; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x = x - dx;
                    y = y + dy;
                    z = z - atan_q32[i];
                end else begin
                    x = x + dx;
                    y = y - dy;
                    z = z + atan_q32[i];
                end
            end
            if (negate) begin
                x = -x;
                y = -y;
            end
            p.x    = coord_t'(round_coord(x));
            p.y    = coord_t'(round_coord(y));
            p.beam = beam_t'(idx);
            return p;
        endfunction

        function void note_beam(logic [psc_pkg::RANGE_W-1:0] range, logic first);
            int unsigned idx;
            idx = first ? 0 : next_beam;
            if (idx >= BEAMS) begin
                idx = 0;
            end
            next_beam = (idx + 1 >= BEAMS) ? 0 : idx + 1;
            expected_points.push_back(project_beam(range, idx));
        endfunction

        function void check_point(coord_t x, coord_t y, beam_t beam);
            beam_point_t exp_p;
            if (expected_points.size() == 0) begin
                $display("%0t unexpected result: x %0d y %0d beam %0d",
                         $time, x, y, beam);
                errors++;
                return;
            end
            exp_p = expected_points.pop_front();
            if (x !== exp_p.x) begin
                $display("%0t beam %0d x_coord: expected %0d, actual %0d",
                         $time, exp_p.beam, exp_p.x, x);
                errors++;
            end
            if (y !== exp_p.y) begin
                $display("%0t beam %0d y_coord: expected %0d, actual %0d",
                         $time, exp_p.beam, exp_p.y, y);
                errors++;
            end
            if (beam !== exp_p.beam) begin
                $display("%0t beam_number: expected %0d, actual %0d",
                         $time, exp_p.beam, beam);
                errors++;
            end
        endfunction

        function int outstanding();
            return expected_points.size();
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn;

    logic                               cfg_wr_en;
    logic [psc_pkg::ADDR_W-1:0]         cfg_addr;
    logic [psc_pkg::CFG_W-1:0]          cfg_wr_data;

    logic                               s_valid;
    logic                               s_ready;
    logic [psc_pkg::RANGE_W-1:0]        s_range_sample;
    logic                               s_first_beam;

    logic                               m_valid;
    logic                               m_ready;
    logic signed [psc_pkg::COORD_W-1:0] m_x_coord;
    logic signed [psc_pkg::COORD_W-1:0] m_y_coord;
    logic [psc_pkg::BEAM_W-1:0]         m_beam_number;

    beam_point_checker #(MAX_BEAMS, ROTATION_STEPS) points;

    int burst_left    = 0;
    int stall_cycles  = 0;
    bit hold_off_req  = 1'b0;
    bit hold_off_done = 1'b0;

    polar_scan_to_cartesian #(
        .MAX_BEAMS      (MAX_BEAMS),
        .ROTATION_STEPS (ROTATION_STEPS)
    ) u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_range_sample (s_range_sample),
        .s_first_beam   (s_first_beam),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_x_coord      (m_x_coord),
        .m_y_coord      (m_y_coord),
        .m_beam_number  (m_beam_number)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            points.note_beam(s_range_sample, s_first_beam);
        end
        if (aresetn && m_valid && m_ready) begin
            points.check_point(m_x_coord, m_y_coord, m_beam_number);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("polar_scan_to_cartesian regression: fail");
            $finish;
        end
    end

    // register writes happen only with the block drained
    task automatic write_settings(logic [psc_pkg::CFG_W-1:0] step,
                                  logic [psc_pkg::CFG_W-1:0] offset);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= psc_pkg::REG_ANGLE_STEP;
        cfg_wr_data <= step;
        @(posedge aclk);
        points.set_reg(psc_pkg::REG_ANGLE_STEP, step);
        cfg_addr    <= psc_pkg::REG_START_OFFSET;
        cfg_wr_data <= offset;
        @(posedge aclk);
        points.set_reg(psc_pkg::REG_START_OFFSET, offset);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic send_beam(logic [psc_pkg::RANGE_W-1:0] range, logic first);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
            burst_left = $urandom_range(1, 48);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid        <= 1'b1;
        s_range_sample <= range;
        s_first_beam   <= first;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wait_idle();
        s_valid    <= 1'b0;
        burst_left = 0;
        while (points.outstanding() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [psc_pkg::RANGE_W-1:0] pick_range();
        case ($urandom_range(0, 7))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(0, 15));
            3: return 16'(16'hFFFF - $urandom_range(0, 15));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // scans of random length, first beam marked, with some flipped markers as noise
    task automatic run_scans(int count, int min_len, int max_len, int noise_pct);
        int   sent;
        int   len;
        logic first;
        sent = 0;
        while (sent < count) begin
            len = $urandom_range(min_len, max_len);
            for (int k = 0; k < len && sent < count; k++) begin
                first = (k == 0);
                if ($urandom_range(0, 99) < noise_pct) begin
                    first = ~first;
                end
                send_beam(pick_range(), first);
                sent++;
            end
        end
    endtask

    initial begin
        rx_mode_t mode;
        int       span;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_off_req && !hold_off_done) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_off_done = 1'b1;
            end
            mode = rx_mode_t'($urandom_range(0, 3));
            span = $urandom_range(16, 200);
            repeat (span) begin
                case (mode)
                    RX_OPEN:   m_ready <= 1'b1;
                    RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                    default:   m_ready <= ~m_ready;
                endcase
                @(posedge aclk);
            end
        end
    end

    initial begin
        points = new();
        aresetn        <= 1'b0;
        cfg_wr_en      <= 1'b0;
        cfg_addr       <= '0;
        cfg_wr_data    <= '0;
        s_valid        <= 1'b0;
        s_range_sample <= '0;
        s_first_beam   <= 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // octants at full range, then zero, tiny and half-scale ranges
        write_settings(16'd8192, 16'd0);
        send_beam(16'hFFFF, 1'b1);
        repeat (7) send_beam(16'hFFFF, 1'b0);
        send_beam(16'd0, 1'b1);
        send_beam(16'd1, 1'b0);
        send_beam(16'h8000, 1'b0);
        wait_idle();

        // just around the quarter and half turn folding points
        write_settings(16'd16385, 16'd1);
        send_beam(16'hFFFF, 1'b1);
        send_beam(16'hFFFF, 1'b0);
        send_beam(16'hFFFF, 1'b0);
        send_beam(16'd40000, 1'b0);
        send_beam(16'd1, 1'b0);
        wait_idle();

        // largest step and offset, index carried over then restarted
        write_settings(16'hFFFF, 16'hFFFF);
        send_beam(16'hFFFF, 1'b0);
        send_beam(16'hFFFF, 1'b1);
        send_beam(16'hFFFF, 1'b0);
        send_beam(16'd12345, 1'b0);
        wait_idle();

        write_settings(16'($urandom), 16'($urandom));
        hold_off_req = 1'b1;
        run_scans(30, 1, 40, 10);
        wait_idle();

        write_settings(16'hFFFF, 16'h0000);
        run_scans(15, 1, 12, 10);
        wait_idle();

        // one scan long enough to wrap the beam index
        write_settings(16'($urandom), 16'($urandom));
        run_scans(MAX_BEAMS + 6, MAX_BEAMS + 6, MAX_BEAMS + 6, 0);
        wait_idle();

        write_settings(16'h0000, 16'hFFFF);
        run_scans(15, 1, 12, 10);
        wait_idle();

        if (points.errors == 0 && points.outstanding() == 0) begin
            $display("polar_scan_to_cartesian regression: pass");
        end else begin
            $display("polar_scan_to_cartesian regression: fail");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/psc_pkg.sv
hw/rtl/psc_cordic.sv
hw/rtl/polar_scan_to_cartesian.sv
tb/tb_polar_scan_to_cartesian.sv
